@@ src/lfd_pkg.sv @@
package lfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 15;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned OutDataW = 24;

  localparam logic [15:0]     MinLength      = 16'd20;
  localparam logic [LenW-1:0] MaxLengthReset = 15'd1500;
  localparam logic [7:0]      DelimReset     = 8'd126;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_LENGTH = 2'd0,
    REG_DELIMITER  = 2'd1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_LEN0 = 3'd0,
    PH_LEN1 = 3'd1,
    PH_DATA = 3'd2,
    PH_TERM = 3'd3,
    PH_HUNT = 3'd4
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    kind_e            kind;
    logic [LenW-1:0]  frame_length;
  } res_t;

endpackage

@@ src/lfd_parser.sv @@
module lfd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lfd_pkg::cfg_wr_t cfg_i,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  output logic           res_valid_o,
  output lfd_pkg::res_t  res_o
);
  import lfd_pkg::*;

  logic [LenW-1:0]  max_len_q;
  logic [7:0]       delim_q;
  phase_e           phase_q, phase_d;
  logic [7:0]       len_low_q, len_low_d;
  logic [LenW-1:0]  plen_q, plen_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [15:0]      raw;
  logic [LenW-1:0]  cnt_inc;
  logic             len_bad;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLengthReset;
      delim_q   <= DelimReset;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        REG_MAX_LENGTH: max_len_q <= cfg_i.wdata;
        REG_DELIMITER:  delim_q   <= cfg_i.wdata[7:0];
        default: ;
      endcase
    end
  end

  assign raw     = {in_byte_i, len_low_q};
  assign cnt_inc = cnt_q + LenW'(1);
  assign len_bad = raw[15] || (raw < MinLength) || (raw[LenW-1:0] > max_len_q);

  always_comb begin
    phase_d     = phase_q;
    len_low_d   = len_low_q;
    plen_d      = plen_q;
    cnt_d       = cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (in_valid_i) begin
      unique case (phase_q)
        PH_LEN0: begin
          len_low_d = in_byte_i;
          phase_d   = PH_LEN1;
        end
        PH_LEN1: begin
          if (len_bad) begin
            // resync from the stored length bytes
            if (len_low_q == delim_q) begin
              len_low_d = in_byte_i;
              phase_d   = PH_LEN1;
            end else if (in_byte_i == delim_q) begin
              phase_d = PH_LEN0;
            end else begin
              phase_d = PH_HUNT;
            end
          end else begin
            plen_d  = raw[LenW-1:0];
            cnt_d   = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= plen_q) begin
            phase_d = PH_TERM;
          end
          res_valid_o    = 1'b1;
          res_o.out_byte = in_byte_i;
          res_o.kind     = KIND_DATA;
        end
        PH_TERM: begin
          res_valid_o        = 1'b1;
          res_o.frame_length = plen_q;
          if (in_byte_i == delim_q) begin
            res_o.kind = KIND_GOOD;
            phase_d    = PH_LEN0;
          end else begin
            res_o.kind = KIND_BAD;
            phase_d    = PH_HUNT;
          end
        end
        default: begin
          phase_d = (in_byte_i == delim_q) ? PH_LEN0 : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN0;
      len_low_q <= '0;
      plen_q    <= '0;
      cnt_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      len_low_q <= len_low_d;
      plen_q    <= plen_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

@@ src/lfd_fifo.sv @@
module lfd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lfd_pkg::res_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lfd_pkg::res_t head_o
);
  import lfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ src/lfd_emitter.sv @@
module lfd_emitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  lfd_pkg::res_t q_head_i,
  output logic          q_pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [lfd_pkg::OutDataW-1:0] m_data_o,
  output logic [lfd_pkg::KindW-1:0]    m_user_o
);
  import lfd_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // refill the output register when it is empty or being taken
  assign q_pop_o = q_valid_i && (!valid_q || m_ready_i);
  assign valid_d = q_pop_o ? 1'b1 : (valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= q_head_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = {1'b0, res_q.frame_length, res_q.out_byte};
  assign m_user_o  = res_q.kind;

endmodule

@@ src/length_prefixed_frame_deframer_core.sv @@
// Length-prefixed frame deframer. One received serial byte is taken per
// transfer on the slave stream; a frame is a signed little-endian 16-bit
// payload length, that many payload bytes and a delimiter byte. Payload
// bytes leave as kind 0 transfers as they arrive; the terminator byte gives
// one end report (kind 1 good, kind 2 terminator mismatch) carrying the
// frame length. Lengths below 20, negative or above max_length are dropped
// silently and the parser resyncs on the delimiter, first in the two stored
// length bytes, then by hunting the incoming stream. The block takes one
// byte every cycle while the result queue has room: the parser state
// machine handles each byte as it is accepted, and a result reaches the
// master stream through a small result queue (FifoDepth entries) and an
// output register. The slave side stalls only when that queue is full, i.e.
// when the master side has been held off for about FifoDepth + 1 results.
// Registers: index 0 max_length (reset 1500), index 1 delimiter (reset
// 126); write them only while the block is idle.
module length_prefixed_frame_deframer_core #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_wdata_i,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [22:8] frame_length, [23] zero
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);
  import lfd_pkg::*;

  cfg_wr_t cfg;
  logic    in_acc;
  logic    res_valid;
  res_t    res;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  res_t    q_head;

  assign cfg.we    = cfg_we_i;
  assign cfg.idx   = cfg_idx_i;
  assign cfg.wdata = cfg_wdata_i;

  // take a byte whenever the queue has room for its possible result
  assign s_axis_tready = !q_full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // front: classify each byte and advance the frame state
  lfd_parser u_parser (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i  (in_acc),
    .in_byte_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // queue between parser and output stage
  lfd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // back: hold the result for the master stream
  lfd_emitter u_emitter (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

  // a result is only produced for an accepted byte, never into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (in_acc && !q_full))
    else $error("result produced without an accepted byte");

  // payload transfers carry no frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_DATA) |-> (m_axis_tdata[23:8] == '0))
    else $error("payload transfer with non-zero length field");

  // end reports carry a zero byte and an accepted length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_GOOD || m_axis_tuser == KIND_BAD))
      |-> (m_axis_tdata[7:0] == '0 && {1'b0, m_axis_tdata[22:8]} >= MinLength))
    else $error("malformed end report");

  // a stalled output transfer holds its content
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed while stalled");

endmodule

@@ dv/testbench.sv @@
module testbench;
  import lfd_pkg::*;

  // Spare register indexes: writes to them must leave both registers untouched
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;
  // Well above the slowest legal run: every byte waits out a sender gap and a stall
  localparam int unsigned CycleLimit = 500000;
  // Cycles to let pass once nothing is expected: a result surfaces through the queue and the output register
  localparam int unsigned SettleCycles = 8;
  // Largest length used for ordinary frames, so that most frames stay short
  localparam int unsigned ShortFrame = 48;

  // Mirror of the parser: tracks the frame state and the registers, and holds
  // the results still owed by the block in arrival order.
  class deframe_board;
    phase_e          phase;
    logic [7:0]      len_lo;
    logic [LenW-1:0] frame_len;
    logic [LenW-1:0] byte_cnt;
    logic [LenW-1:0] max_len;
    logic [7:0]      delim;
    res_t            due[$];
    int unsigned     faults;
    int unsigned     payloads;
    int unsigned     goods;
    int unsigned     bads;

    function new();
      phase     = PH_LEN0;
      len_lo    = '0;
      frame_len = '0;
      byte_cnt  = '0;
      max_len   = MaxLengthReset;
      delim     = DelimReset;
      faults    = 0;
      payloads  = 0;
      goods     = 0;
      bads      = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      if (idx == REG_MAX_LENGTH) max_len = val;
      else if (idx == REG_DELIMITER) delim = val[7:0];
    endfunction

    // Signed little-endian length: negative, short or over the limit is refused
    function bit length_ok(logic [15:0] raw);
      return !raw[15] && raw >= MinLength && raw[14:0] <= max_len;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    // Advance the parser by one accepted byte and queue what it must produce
    function void parse_byte(logic [7:0] b);
      logic [15:0] raw;
      res_t        item;
      item = '0;
      case (phase)
        PH_LEN0: begin
          len_lo = b;
          phase  = PH_LEN1;
        end
        PH_LEN1: begin
          raw = {b, len_lo};
          if (!length_ok(raw)) begin
            // resync: a stored delimiter restarts the length right after it
            if (len_lo == delim) len_lo = b;
            else if (b == delim) phase = PH_LEN0;
            else phase = PH_HUNT;
          end else begin
            frame_len = raw[14:0];
            byte_cnt  = '0;
            phase     = PH_DATA;
          end
        end
        PH_DATA: begin
          byte_cnt = byte_cnt + 15'd1;
          if (byte_cnt >= frame_len) phase = PH_TERM;
          item.out_byte = b;
          item.kind     = KIND_DATA;
          due.push_back(item);
        end
        PH_TERM: begin
          item.frame_length = frame_len;
          if (b == delim) begin
            item.kind = KIND_GOOD;
            phase     = PH_LEN0;
          end else begin
            item.kind = KIND_BAD;
            phase     = PH_HUNT;
          end
          due.push_back(item);
        end
        default: begin
          if (b == delim) phase = PH_LEN0;
          else phase = PH_HUNT;
        end
      endcase
    endfunction

    // Compare one master-side transfer against the oldest owed result
    function void take_result(logic [OutDataW-1:0] data, logic [KindW-1:0] kind);
      res_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected result: byte %02h kind %0d length %0d",
                 $time, data[7:0], kind, data[22:8]);
        faults++;
        return;
      end
      want = due.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
        faults++;
      end
      if (data[7:0] !== want.out_byte) begin
        $display("%0t: out_byte expected %02h got %02h", $time, want.out_byte, data[7:0]);
        faults++;
      end
      if (data[22:8] !== want.frame_length) begin
        $display("%0t: frame_length expected %0d got %0d",
                 $time, want.frame_length, data[22:8]);
        faults++;
      end
      if (data[23] !== 1'b0) begin
        $display("%0t: tdata pad bit expected 0 got %b", $time, data[23]);
        faults++;
      end
      case (want.kind)
        KIND_DATA: payloads++;
        KIND_GOOD: goods++;
        default:   bads++;
      endcase
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [CfgW-1:0]       cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] rx_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;   // [7:0] out_byte, [22:8] frame_length, [23] zero
  logic [KindW-1:0]      m_axis_tuser;   // [1:0] kind

  deframe_board board;
  int unsigned  sent;
  int unsigned  settings;
  int unsigned  cycles;
  bit           send_gaps;
  bit           take_stalls;
  int unsigned  send_calm;
  int unsigned  take_calm;
  int unsigned  hold;

  length_prefixed_frame_deframer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a run that hangs on a missing result ends here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: run exceeded %0d cycles, %0d results still owed",
               $time, CycleLimit, board.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Master side: check every transfer and drop tready in short random bursts,
  // with calm stretches in between and none at all once stalls are switched off.
  initial begin
    m_axis_tready <= 1'b0;
    hold = 0;
    take_calm = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.take_result(m_axis_tdata, m_axis_tuser);
      if (hold > 0) begin
        hold--;
      end else if (take_stalls) begin
        if (take_calm > 0) take_calm--;
        else if ($urandom_range(0, 31) == 0) take_calm = $urandom_range(20, 60);
        else if ($urandom_range(0, 4) == 0) hold = $urandom_range(1, 4);
      end
      m_axis_tready <= (hold == 0);
    end
  end

  // Offer one byte on the slave side, optionally after a short gap, and hold it
  // until the transfer completes; tvalid stays high into the next byte.
  task automatic push(input logic [7:0] b);
    if (send_gaps) begin
      if (send_calm > 0) begin
        send_calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        send_calm = $urandom_range(10, 40);
      end else if ($urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    board.parse_byte(b);
    sent++;
  endtask

  // Wait until every owed result has arrived, then let the pipeline run empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Delimiter writes carry random junk above bit 7, which must be dropped
  task automatic set_limits(input logic [LenW-1:0] max_len, input logic [7:0] delim);
    program_reg(REG_MAX_LENGTH, max_len);
    program_reg(REG_DELIMITER, {7'($urandom), delim});
    settings++;
  endtask

  function automatic logic [7:0] not_delim();
    logic [7:0] b;
    do b = 8'($urandom); while (b == board.delim);
    return b;
  endfunction

  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 7) == 0) return board.delim;
    return 8'($urandom);
  endfunction

  // Mostly short legal lengths, with the limit itself now and then when it is small
  function automatic int unsigned pick_len();
    int unsigned top;
    if (board.max_len < MinLength) return $urandom_range(0, ShortFrame);
    if (board.max_len <= 15'(2 * ShortFrame) && $urandom_range(0, 49) == 0)
      return int'(board.max_len);
    if ($urandom_range(0, 9) == 0) return MinLength;
    top = (board.max_len < ShortFrame) ? board.max_len : ShortFrame;
    return $urandom_range(MinLength, top);
  endfunction

  task automatic frame_body(input int unsigned len, input bit good);
    repeat (len) push(payload_byte());
    if (good) push(board.delim);
    else push(not_delim());
  endtask

  task automatic frame(input int unsigned len, input bit good);
    logic [15:0] raw;
    raw = 16'(len);
    push(raw[7:0]);
    push(raw[15:8]);
    frame_body(len, good);
  endtask

  task automatic hunt_noise();
    repeat ($urandom_range(0, 3)) push(not_delim());
  endtask

  // Steer the parser back to the start of a frame using only bytes whose
  // effect is known: finish a payload, refuse a length by its sign bit, and
  // send the delimiter while hunting or at the terminator.
  task automatic to_frame_start();
    while (board.phase != PH_LEN0) begin
      case (board.phase)
        PH_LEN1: begin
          logic [7:0] b;
          do b = 8'($urandom) | 8'h80; while (b == board.delim);
          push(b);
        end
        PH_DATA: push(payload_byte());
        default: push(board.delim);
      endcase
    end
  endtask

  // Refused length of every flavour, with the delimiter planted in either
  // stored byte so that both resync paths are taken.
  task automatic broken_length();
    logic [15:0] raw;
    logic [7:0]  lead;
    case ($urandom_range(0, 3))
      0: raw = {1'b1, 15'($urandom)};
      1: raw = $urandom_range(0, 1) ? (MinLength - 16'd1) : 16'($urandom_range(0, 19));
      2: begin
        if (board.max_len == '1) raw = {1'b1, 15'($urandom)};
        else if ($urandom_range(0, 1)) raw = 16'(board.max_len) + 16'd1;
        else raw = 16'($urandom_range(int'(board.max_len) + 1, 32767));
      end
      default: begin
        // delimiter first: the next byte restarts as the low length byte
        lead = 8'(pick_len());
        if (!board.length_ok({lead, board.delim})) begin
          push(board.delim);
          push(lead);
          push(8'h00);
          frame_body(int'(lead), $urandom_range(0, 3) != 0);
          return;
        end
        raw = {1'b1, 15'($urandom)};
      end
    endcase
    case ($urandom_range(0, 2))
      0: if (!board.length_ok({raw[15:8], board.delim})) raw[7:0] = board.delim;
      1: if (!board.length_ok({board.delim, raw[7:0]})) raw[15:8] = board.delim;
      default: ;
    endcase
    push(raw[7:0]);
    push(raw[15:8]);
  endtask

  // Mostly well-formed frames; the rest are bad terminators, refused lengths
  // and, where the limit keeps stray frames short, raw line noise.
  task automatic random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned r;
    stop_at = sent + count;
    while (sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        frame(pick_len(), 1'b1);
      end else if (r < 67) begin
        frame(pick_len(), 1'b0);
        hunt_noise();
      end else if (r < 90) begin
        broken_length();
        if (board.phase == PH_HUNT) hunt_noise();
      end else if (board.max_len <= 15'(2 * ShortFrame)) begin
        repeat ($urandom_range(2, 8)) push(8'($urandom));
      end
      to_frame_start();
    end
  endtask

  initial begin
    board = new();
    sent = 0;
    settings = 1;
    cycles = 0;
    send_calm = 0;
    send_gaps = 1'b1;
    take_stalls = 1'b1;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_MAX_LENGTH;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset registers (limit 1500, delimiter 7E).
    // Negative length, neither byte a delimiter: hunt, then resync.
    push(8'h00); push(8'h80); push(8'h7e);
    // Over the limit with the delimiter as second byte: fresh length next.
    push(8'h13); push(8'h7e);
    // One below the minimum: hunt, then resync.
    push(8'h13); push(8'h00); push(8'h7e);
    // Delimiter as first stored byte: 14h becomes the low byte of a 20-byte frame,
    // whose payload spans both byte extremes and the delimiter itself.
    push(8'h7e); push(8'h14); push(8'h00);
    push(8'h00); push(8'hff); push(8'h7e);
    repeat (17) push(8'($urandom));
    push(8'h7e);
    random_traffic(250);
    settle();

    // Limit equal to the minimum, zero delimiter
    set_limits(15'd20, 8'h00);
    random_traffic(150);
    settle();

    // Widest limit, all-ones delimiter; only negative and short lengths are refused
    set_limits(15'h7fff, 8'hff);
    random_traffic(200);
    settle();

    // A limit below the minimum refuses every length; spare indexes do nothing
    send_gaps = 1'b0;
    set_limits(15'd19, 8'h55);
    program_reg(RegSpare2, 15'h7fff);
    program_reg(RegSpare3, 15'h0000);
    random_traffic(80);
    settle();
    send_gaps = 1'b1;
    take_stalls = 1'b0;
    set_limits(15'd0, 8'($urandom));
    random_traffic(40);
    settle();

    // Random small limit and delimiter
    take_stalls = 1'b1;
    set_limits(15'($urandom_range(21, 80)), 8'($urandom));
    random_traffic(250);
    settle();

    // Back to the reset values, full rate on both sides
    send_gaps = 1'b0;
    take_stalls = 1'b0;
    set_limits(MaxLengthReset, DelimReset);
    random_traffic(250);
    settle();

    $display("Sent %0d bytes over %0d register settings, spare indexes included.",
             sent, settings);
    $display("Checked %0d payload transfers, %0d good and %0d bad frame ends.",
             board.payloads, board.goods, board.bads);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", board.faults, board.pending());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ length_prefixed_frame_deframer_core.f @@
src/lfd_pkg.sv
src/lfd_parser.sv
src/lfd_fifo.sv
src/lfd_emitter.sv
src/length_prefixed_frame_deframer_core.sv
dv/testbench.sv
